// ===== hw/rtl/length_xor_frame_receiver_defines.svh =====
// Assertion macros for the length/XOR frame receiver.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_XOR_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define LXFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("lxfr assertion failed");
// Checked on every edge, reset included.
`define LXFR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lxfr assertion failed");
`else
`define LXFR_ASSERT(lbl, clk, rst_n, prop)
`define LXFR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/lxfr_pkg.sv =====
// Shared types and codes for the length/XOR frame receiver.
// No dependencies.
package lxfr_pkg;

    typedef enum logic [2:0] {
        ROLE_DEVICE   = 3'd0,
        ROLE_LEN_HI   = 3'd1,
        ROLE_LEN_LO   = 3'd2,
        ROLE_COMMAND  = 3'd3,
        ROLE_PAYLOAD  = 3'd4,
        ROLE_CHECKSUM = 3'd5
    } t_role;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_SHORT    = 2'd3
    } t_status;

    localparam int LEN_W   = 16;
    localparam int COUNT_W = LEN_W + 1;
    // Count saturates here; never equal to any declared length.
    localparam logic [COUNT_W-1:0] COUNT_SAT = {1'b1, {LEN_W{1'b0}}};

    typedef struct packed {
        logic [7:0] byte_out;
        t_role      byte_role;
        logic       frame_done;
        t_status    frame_status;
        logic [7:0] device_id;
    } t_result;

endpackage

// ===== hw/rtl/lxfr_in_if.sv =====
// Input channel: one received frame byte per word.
// Depends on nothing.
interface lxfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/lxfr_out_if.sv =====
// Output channel: echoed byte with role and frame status per word.
// Depends on nothing.
interface lxfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [7:0] device_id;

    modport source (output valid, output byte_out, output byte_role, output frame_done,
                    output frame_status, output device_id, input ready);
    modport sink   (input valid, input byte_out, input byte_role, input frame_done,
                    input frame_status, input device_id, output ready);
endinterface

// ===== hw/rtl/lxfr_parser.sv =====
// Frame state tracking: header position, length, payload count and XOR.
// Produces the result word for the current byte; depends on lxfr_pkg.
module lxfr_parser
    import lxfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        POS_DEVICE  = 2'd0,
        POS_LEN_HI  = 2'd1,
        POS_LEN_LO  = 2'd2,
        POS_PAYLOAD = 2'd3
    } t_pos;

    t_pos               r_pos,    n_pos;
    logic [LEN_W-1:0]   r_len,    n_len;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [7:0]         r_xor,    n_xor;
    logic [7:0]         r_device, n_device;

    always_comb begin
        n_pos    = r_pos;
        n_len    = r_len;
        n_count  = r_count;
        n_xor    = r_xor;
        n_device = r_device;

        o_result.byte_out     = i_rx_byte;
        o_result.byte_role    = ROLE_PAYLOAD;
        o_result.frame_done   = 1'b0;
        o_result.frame_status = ST_OK;

        if (i_end_of_frame) begin
            o_result.byte_role  = ROLE_CHECKSUM;
            o_result.frame_done = 1'b1;
            if (r_pos != POS_PAYLOAD) begin
                o_result.frame_status = ST_SHORT;
            end else if (r_count != {1'b0, r_len}) begin
                o_result.frame_status = ST_LENGTH;
            end else if (r_xor != i_rx_byte) begin
                o_result.frame_status = ST_CHECKSUM;
            end
            n_pos   = POS_DEVICE;
            n_len   = '0;
            n_count = '0;
            n_xor   = '0;
        end else begin
            case (r_pos)
                POS_DEVICE: begin
                    o_result.byte_role = ROLE_DEVICE;
                    n_device           = i_rx_byte;
                    n_pos              = POS_LEN_HI;
                end
                POS_LEN_HI: begin
                    o_result.byte_role = ROLE_LEN_HI;
                    n_len              = {i_rx_byte, 8'h00};
                    n_pos              = POS_LEN_LO;
                end
                POS_LEN_LO: begin
                    o_result.byte_role = ROLE_LEN_LO;
                    n_len              = {r_len[LEN_W-1:8], i_rx_byte};
                    n_pos              = POS_PAYLOAD;
                end
                default: begin
                    o_result.byte_role = (r_count == '0) ? ROLE_COMMAND : ROLE_PAYLOAD;
                    n_xor              = r_xor ^ i_rx_byte;
                    if (r_count != COUNT_SAT) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
            endcase
        end

        // device_id reflects the state after this byte
        o_result.device_id = n_device;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_DEVICE;
            r_len    <= '0;
            r_count  <= '0;
            r_xor    <= '0;
            r_device <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_count  <= n_count;
            r_xor    <= n_xor;
            r_device <= n_device;
        end
    end

endmodule

// ===== hw/rtl/lxfr_skid.sv =====
// Two-entry output buffer holding result words; decouples input ready
// from output ready. Depends on lxfr_pkg.
module lxfr_skid
    import lxfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_push_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;
    logic    w_push;

    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_data       = r_main;
    assign w_pop        = r_main_valid && i_ready;
    assign w_push       = i_push && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_main_valid || w_pop) begin
                r_main       <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/length_xor_frame_receiver.sv =====
// Length-prefixed frame receiver with XOR checksum, top level.
// Depends on lxfr_pkg, lxfr_in_if, lxfr_out_if, lxfr_parser, lxfr_skid.
//
// Usage: frame bytes enter on i_rx, one byte per word, end_of_frame set on
// the final (checksum) byte. Byte 0 is the device id, bytes 1-2 the
// big-endian payload length, then payload (first byte is the command).
// Every input word yields exactly one word on o_res: the byte echoed with
// its role, and on the final byte frame_done with the status
// (ok, too short, length mismatch, checksum mismatch; first hit wins).
// Payload counts past 65535 saturate and report a length mismatch.
//
// Results are registered in the output buffer before they reach o_res.
// Throughput: one word per cycle while the output buffer has room; the only per-byte loop is the frame
// state register update (count step, XOR, compare).
// Reset (synchronous, i_rst_n low): frame state and captured device go to
// zero, the output buffer empties.
// Stall: a two-entry output buffer holds results; i_rx.ready drops only
// when both entries are full, and it depends on registered state alone.
`include "length_xor_frame_receiver_defines.svh"

module length_xor_frame_receiver
    import lxfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lxfr_in_if.sink    i_rx,
    lxfr_out_if.source o_res
);

    logic    w_accept;
    logic    w_in_ready;
    t_result w_result;
    t_result w_out;

    assign i_rx.ready = w_in_ready;
    assign w_accept   = i_rx.valid && w_in_ready;

    lxfr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_rx.rx_byte),
        .i_end_of_frame (i_rx.end_of_frame),
        .o_result       (w_result)
    );

    lxfr_skid u_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_rx.valid),
        .o_push_ready (w_in_ready),
        .i_data       (w_result),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_data       (w_out)
    );

    assign o_res.byte_out     = w_out.byte_out;
    assign o_res.byte_role    = w_out.byte_role;
    assign o_res.frame_done   = w_out.frame_done;
    assign o_res.frame_status = w_out.frame_status;
    assign o_res.device_id    = w_out.device_id;

    // buffer can only be full while a word is on offer
    `LXFR_ASSERT(a_full_has_out, i_clk, i_rst_n, !i_rx.ready |-> o_res.valid)
    // status is only nonzero on the final byte
    `LXFR_ASSERT(a_status_only_done, i_clk, i_rst_n,
        (o_res.valid && !o_res.frame_done) |-> (o_res.frame_status == ST_OK))
    // final byte is always tagged as checksum
    `LXFR_ASSERT(a_done_role, i_clk, i_rst_n,
        (o_res.valid && o_res.frame_done) |-> (o_res.byte_role == ROLE_CHECKSUM))
    // nothing left over after reset
    `LXFR_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!o_res.valid && i_rx.ready))

endmodule
